// ----- rtl/ssc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

    // fixed point of the throttle filter
    localparam int FILTER_FRAC_BITS = 20;
    localparam int THR_W            = 7;
    localparam int FILT_W           = THR_W + FILTER_FRAC_BITS;
    localparam int GAIN_W           = 20;
    localparam int PERIOD_W         = 16;
    localparam int LIMIT_W          = 8;
    localparam int CFG_DATA_W       = 20;
    localparam int CFG_INDEX_W      = 3;

    localparam logic [THR_W-1:0] THR_MAX = 7'd100;

    // reciprocal constants for division by a constant
    localparam int          RECIP10_SHIFT  = 22;
    localparam logic [19:0] RECIP10        = 20'd838861;
    localparam int          RECIP15_SHIFT  = 24;
    localparam logic [20:0] RECIP15        = 21'd1118482;
    localparam int          RECIP100_SHIFT = 26;
    localparam logic [21:0] RECIP100       = 22'd2684355;

    // reset values of the registers
    localparam logic [PERIOD_W-1:0] ALIGN_STEP_PERIOD_RST = 16'd1000;
    localparam logic [PERIOD_W-1:0] RAMP_STEP_PERIOD_RST  = 16'd2000;
    localparam logic [PERIOD_W-1:0] RAMP_PWM_PERIOD_RST   = 16'd5000;
    localparam logic [LIMIT_W-1:0]  RAMP_STEP_LIMIT_RST   = 8'd10;
    localparam logic [GAIN_W-1:0]   FILTER_GAIN_RST       = 20'd524;
    localparam logic [PERIOD_W-1:0] DUTY_RST              = 16'd100;
    localparam logic [2:0]          STEP_RST              = 3'd6;
    localparam logic [2:0]          STEP_FIRST            = 3'd1;
    localparam logic [2:0]          STEP_LAST             = 3'd6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALIGN_STEP_PERIOD = 3'd0,
        CFG_RAMP_STEP_PERIOD  = 3'd1,
        CFG_RAMP_PWM_PERIOD   = 3'd2,
        CFG_RAMP_STEP_LIMIT   = 3'd3,
        CFG_FILTER_GAIN       = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ALIGN = 2'd1,
        CMD_RAMP  = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAGE_ALIGN = 2'd0,
        STAGE_RAMP  = 2'd1,
        STAGE_RUN   = 2'd2,
        STAGE_OFF   = 2'd3
    } stage_t;

    typedef enum logic [1:0] {
        PHASE_A    = 2'd0,
        PHASE_B    = 2'd1,
        PHASE_C    = 2'd2,
        PHASE_NONE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        TRUN_LEAVE   = 2'd0,
        TRUN_ENABLE  = 2'd1,
        TRUN_DISABLE = 2'd2
    } trun_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RAMP_MUL,
        OP_RAMP_DUTY,
        OP_RUN_DIFF,
        OP_RUN_MUL,
        OP_RUN_UPD,
        OP_RUN_SPAN,
        OP_RUN_LMUL,
        OP_RUN_QMUL,
        OP_RUN_DUTY
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RAMP_MUL,
        ST_RAMP_DUTY,
        ST_RUN_DIFF,
        ST_RUN_MUL,
        ST_RUN_UPD,
        ST_RUN_SPAN,
        ST_RUN_LMUL,
        ST_RUN_QMUL,
        ST_RUN_DUTY,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        stage_t stage;
    } dp_status_t;

    typedef struct packed {
        logic [2:0]          mask;
        phase_t              pwm_phase;
        phase_t              sense;
        logic                rise;
    } comm_t;

    typedef struct packed {
        logic [2:0]          phase_enable_mask;
        logic [PERIOD_W-1:0] duty_a;
        logic [PERIOD_W-1:0] duty_b;
        logic [PERIOD_W-1:0] duty_c;
        logic [1:0]          sense_phase;
        logic                sense_rising;
        logic [PERIOD_W-1:0] pwm_period_out;
        logic [PERIOD_W-1:0] step_timer_period;
        logic [1:0]          step_timer_run;
        logic [1:0]          stage_out;
        logic [2:0]          step_out;
    } res_t;

    function automatic logic [2:0] step_advance(input logic [2:0] s);
        logic [2:0] n;
        if (s >= STEP_LAST || s == 3'd0)
            n = STEP_FIRST;
        else
            n = s + 3'd1;
        return n;
    endfunction

    // enable mask, pwm phase and back-emf watch for each step
    function automatic comm_t step_phase(input logic [2:0] s);
        comm_t c;
        unique case (s)
            3'd1:    c = '{3'd3, PHASE_B, PHASE_C, 1'b0};
            3'd2:    c = '{3'd5, PHASE_C, PHASE_B, 1'b1};
            3'd3:    c = '{3'd6, PHASE_C, PHASE_A, 1'b0};
            3'd4:    c = '{3'd3, PHASE_A, PHASE_C, 1'b1};
            3'd5:    c = '{3'd5, PHASE_A, PHASE_B, 1'b0};
            3'd6:    c = '{3'd6, PHASE_B, PHASE_A, 1'b1};
            default: c = '{3'd0, PHASE_NONE, PHASE_NONE, 1'b0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ssc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ssc_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic [ssc_pkg::THR_W-1:0] throttle;

    modport source (output valid, output command, output throttle, input ready);
    modport sink   (input valid, input command, input throttle, output ready);
endinterface

interface ssc_res_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   phase_enable_mask;
    logic [ssc_pkg::PERIOD_W-1:0] duty_a;
    logic [ssc_pkg::PERIOD_W-1:0] duty_b;
    logic [ssc_pkg::PERIOD_W-1:0] duty_c;
    logic [1:0]                   sense_phase;
    logic                         sense_rising;
    logic [ssc_pkg::PERIOD_W-1:0] pwm_period_out;
    logic [ssc_pkg::PERIOD_W-1:0] step_timer_period;
    logic [1:0]                   step_timer_run;
    logic [1:0]                   stage_out;
    logic [2:0]                   step_out;

    modport source (
        output valid, input ready,
        output phase_enable_mask, output duty_a, output duty_b, output duty_c,
        output sense_phase, output sense_rising, output pwm_period_out,
        output step_timer_period, output step_timer_run, output stage_out,
        output step_out
    );
    modport sink (
        input valid, output ready,
        input phase_enable_mask, input duty_a, input duty_b, input duty_c,
        input sense_phase, input sense_rising, input pwm_period_out,
        input step_timer_period, input step_timer_run, input stage_out,
        input step_out
    );
endinterface

`default_nettype wire

// ----- rtl/ssc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ssc_pkg::dp_status_t status,
    output ssc_pkg::dp_cmd_t    cmd
);

    ssc_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 can_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result slot is free when empty or being drained this cycle
    assign can_emit = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.op     = ssc_pkg::OP_NONE;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ssc_pkg::ST_DISPATCH;
                end
            end
            ssc_pkg::ST_DISPATCH:
            begin
                unique case (status.stage)
                    ssc_pkg::STAGE_RAMP: state_next = ssc_pkg::ST_RAMP_MUL;
                    ssc_pkg::STAGE_RUN:  state_next = ssc_pkg::ST_RUN_DIFF;
                    default:             state_next = ssc_pkg::ST_EMIT;
                endcase
            end
            ssc_pkg::ST_RAMP_MUL:
            begin
                cmd.op     = ssc_pkg::OP_RAMP_MUL;
                state_next = ssc_pkg::ST_RAMP_DUTY;
            end
            ssc_pkg::ST_RAMP_DUTY:
            begin
                cmd.op     = ssc_pkg::OP_RAMP_DUTY;
                state_next = ssc_pkg::ST_EMIT;
            end
            ssc_pkg::ST_RUN_DIFF:
            begin
                cmd.op     = ssc_pkg::OP_RUN_DIFF;
                state_next = ssc_pkg::ST_RUN_MUL;
            end
            ssc_pkg::ST_RUN_MUL:
            begin
                cmd.op     = ssc_pkg::OP_RUN_MUL;
                state_next = ssc_pkg::ST_RUN_UPD;
            end
            ssc_pkg::ST_RUN_UPD:
            begin
                cmd.op     = ssc_pkg::OP_RUN_UPD;
                state_next = ssc_pkg::ST_RUN_SPAN;
            end
            ssc_pkg::ST_RUN_SPAN:
            begin
                cmd.op     = ssc_pkg::OP_RUN_SPAN;
                state_next = ssc_pkg::ST_RUN_LMUL;
            end
            ssc_pkg::ST_RUN_LMUL:
            begin
                cmd.op     = ssc_pkg::OP_RUN_LMUL;
                state_next = ssc_pkg::ST_RUN_QMUL;
            end
            ssc_pkg::ST_RUN_QMUL:
            begin
                cmd.op     = ssc_pkg::OP_RUN_QMUL;
                state_next = ssc_pkg::ST_RUN_DUTY;
            end
            ssc_pkg::ST_RUN_DUTY:
            begin
                cmd.op     = ssc_pkg::OP_RUN_DUTY;
                state_next = ssc_pkg::ST_EMIT;
            end
            ssc_pkg::ST_EMIT:
            begin
                if (can_emit)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/ssc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssc_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ssc_pkg::dp_cmd_t                        cmd,
    output ssc_pkg::dp_status_t                     status,
    input  logic [1:0]                              in_command,
    input  logic [ssc_pkg::THR_W-1:0]               in_throttle,
    input  logic                                    cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]          cfg_data,
    output ssc_pkg::res_t                           res
);

    localparam int PW      = ssc_pkg::PERIOD_W;
    localparam int FW      = ssc_pkg::FILT_W;
    localparam int GW      = ssc_pkg::GAIN_W;
    localparam int NINE_W  = PW + 4;
    localparam int GPROD_W = FW + GW;
    localparam int LOP_W   = PW - 1 + $bits(ssc_pkg::RECIP10);
    localparam int HIP_W   = NINE_W - 1 + $bits(ssc_pkg::RECIP10);
    localparam int RPROD_W = PW - 1 + $bits(ssc_pkg::RECIP15);
    localparam int LPROD_W = ssc_pkg::THR_W + PW;
    localparam int QPROD_W = LPROD_W - 2 + $bits(ssc_pkg::RECIP100);

    // configuration
    logic [PW-1:0]                align_period_reg, align_period_next;
    logic [PW-1:0]                ramp_period_reg, ramp_period_next;
    logic [PW-1:0]                ramp_pwm_reg, ramp_pwm_next;
    logic [ssc_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic [GW-1:0]                gain_reg, gain_next;

    // sequencer state
    logic [2:0]                   step_reg, step_next;
    ssc_pkg::stage_t              stage_reg, stage_next;
    logic [ssc_pkg::LIMIT_W-1:0]  cnt_reg, cnt_next;
    logic [FW-1:0]                filt_reg, filt_next;
    logic [PW-1:0]                duty_reg, duty_next;
    logic [PW-1:0]                pwm_reg, pwm_next;

    // working registers
    logic [ssc_pkg::THR_W-1:0]    thr_reg;
    logic [FW-1:0]                d_reg;
    logic                         up_reg;
    logic [NINE_W-1:0]            nine_reg;
    logic [GPROD_W-1:0]           gprod_reg;
    logic [LOP_W-1:0]             lo_prod_reg;
    logic [HIP_W-1:0]             hi_prod_reg;
    logic [PW-1:0]                lo_reg;
    logic [PW-1:0]                hi9_reg;
    logic [PW-1:0]                span_reg;
    logic [LPROD_W-1:0]           lprod_reg;
    logic [QPROD_W-1:0]           qprod_reg;
    logic [RPROD_W-1:0]           rprod_reg;
    ssc_pkg::res_t                res_reg, res_next;

    logic [FW-1:0]                target;
    logic [FW-1:0]                delta;
    logic [ssc_pkg::THR_W-1:0]    level;
    logic [ssc_pkg::LIMIT_W:0]    cnt_sum;
    logic [2:0]                   step_adv;
    ssc_pkg::comm_t               comm;

    assign target   = {thr_reg, {ssc_pkg::FILTER_FRAC_BITS{1'b0}}};
    assign delta    = gprod_reg[GW +: FW];
    assign level    = filt_reg[FW-1 -: ssc_pkg::THR_W];
    assign cnt_sum  = {1'b0, cnt_reg} + {{ssc_pkg::LIMIT_W{1'b0}}, 1'b1};
    assign step_adv = ssc_pkg::step_advance(step_reg);
    assign comm     = ssc_pkg::step_phase(step_adv);

    always_comb
    begin
        align_period_next = align_period_reg;
        ramp_period_next  = ramp_period_reg;
        ramp_pwm_next     = ramp_pwm_reg;
        limit_next        = limit_reg;
        gain_next         = gain_reg;
        if (cfg_we)
        begin
            unique case (ssc_pkg::cfg_index_t'(cfg_index))
                ssc_pkg::CFG_ALIGN_STEP_PERIOD: align_period_next = cfg_data[PW-1:0];
                ssc_pkg::CFG_RAMP_STEP_PERIOD:  ramp_period_next  = cfg_data[PW-1:0];
                ssc_pkg::CFG_RAMP_PWM_PERIOD:   ramp_pwm_next     = cfg_data[PW-1:0];
                ssc_pkg::CFG_RAMP_STEP_LIMIT:   limit_next = cfg_data[ssc_pkg::LIMIT_W-1:0];
                ssc_pkg::CFG_FILTER_GAIN:       gain_next         = cfg_data[GW-1:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        step_next  = step_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        filt_next  = filt_reg;
        duty_next  = duty_reg;
        pwm_next   = pwm_reg;
        res_next   = res_reg;

        // stage write from the command of the new item
        if (cmd.load)
        begin
            unique case (ssc_pkg::cmd_t'(in_command))
                ssc_pkg::CMD_ALIGN: stage_next = ssc_pkg::STAGE_ALIGN;
                ssc_pkg::CMD_RAMP:  stage_next = ssc_pkg::STAGE_RAMP;
                ssc_pkg::CMD_STOP:  stage_next = ssc_pkg::STAGE_OFF;
                default:            stage_next = stage_reg;
            endcase
        end

        case (cmd.op)
            ssc_pkg::OP_RAMP_MUL:  pwm_next  = ramp_pwm_reg;
            ssc_pkg::OP_RAMP_DUTY: duty_next = PW'(rprod_reg[RPROD_W-1:ssc_pkg::RECIP15_SHIFT]);
            ssc_pkg::OP_RUN_UPD:   filt_next = up_reg ? filt_reg + delta : filt_reg - delta;
            ssc_pkg::OP_RUN_DUTY:
                duty_next = lo_reg + PW'(qprod_reg[QPROD_W-1:ssc_pkg::RECIP100_SHIFT]);
            default: ;
        endcase

        if (cmd.emit)
        begin
            res_next.phase_enable_mask = comm.mask;
            res_next.duty_a       = (comm.pwm_phase == ssc_pkg::PHASE_A) ? duty_reg : '0;
            res_next.duty_b       = (comm.pwm_phase == ssc_pkg::PHASE_B) ? duty_reg : '0;
            res_next.duty_c       = (comm.pwm_phase == ssc_pkg::PHASE_C) ? duty_reg : '0;
            res_next.sense_phase  = comm.sense;
            res_next.sense_rising = comm.rise;
            res_next.step_timer_period = '0;
            res_next.step_timer_run    = ssc_pkg::TRUN_LEAVE;
            step_next = step_adv;
            unique case (stage_reg)
                ssc_pkg::STAGE_ALIGN:
                begin
                    res_next.step_timer_period = align_period_reg;
                    res_next.step_timer_run    = ssc_pkg::TRUN_ENABLE;
                    cnt_next = '0;
                end
                ssc_pkg::STAGE_RAMP:
                begin
                    res_next.step_timer_period = ramp_period_reg;
                    cnt_next = cnt_sum[ssc_pkg::LIMIT_W] ? '1 : cnt_sum[ssc_pkg::LIMIT_W-1:0];
                    if (cnt_sum > {1'b0, limit_reg})
                        stage_next = ssc_pkg::STAGE_RUN;
                end
                ssc_pkg::STAGE_RUN:
                begin
                    res_next.step_timer_run = ssc_pkg::TRUN_DISABLE;
                end
                default:
                begin
                    // stopped: no commutation, drivers off
                    step_next = step_reg;
                    pwm_next  = '0;
                    res_next.phase_enable_mask = '0;
                    res_next.duty_a       = '0;
                    res_next.duty_b       = '0;
                    res_next.duty_c       = '0;
                    res_next.sense_phase  = ssc_pkg::PHASE_NONE;
                    res_next.sense_rising = 1'b0;
                end
            endcase
            res_next.pwm_period_out = pwm_next;
            res_next.stage_out      = stage_next;
            res_next.step_out       = (stage_next == ssc_pkg::STAGE_OFF) ? 3'd0 : step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_period_reg <= ssc_pkg::ALIGN_STEP_PERIOD_RST;
            ramp_period_reg  <= ssc_pkg::RAMP_STEP_PERIOD_RST;
            ramp_pwm_reg     <= ssc_pkg::RAMP_PWM_PERIOD_RST;
            limit_reg        <= ssc_pkg::RAMP_STEP_LIMIT_RST;
            gain_reg         <= ssc_pkg::FILTER_GAIN_RST;
            step_reg         <= ssc_pkg::STEP_RST;
            stage_reg        <= ssc_pkg::STAGE_OFF;
            cnt_reg          <= '0;
            filt_reg         <= '0;
            duty_reg         <= ssc_pkg::DUTY_RST;
            pwm_reg          <= '0;
        end
        else
        begin
            align_period_reg <= align_period_next;
            ramp_period_reg  <= ramp_period_next;
            ramp_pwm_reg     <= ramp_pwm_next;
            limit_reg        <= limit_next;
            gain_reg         <= gain_next;
            step_reg         <= step_next;
            stage_reg        <= stage_next;
            cnt_reg          <= cnt_next;
            filt_reg         <= filt_next;
            duty_reg         <= duty_next;
            pwm_reg          <= pwm_next;
        end
    end

    // arithmetic pipeline, one registered step per command
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.load)
            thr_reg <= (in_throttle > ssc_pkg::THR_MAX) ? ssc_pkg::THR_MAX : in_throttle;
        case (cmd.op)
            ssc_pkg::OP_RAMP_MUL:
                rprod_reg <= RPROD_W'(ramp_pwm_reg[PW-1:1]) * RPROD_W'(ssc_pkg::RECIP15);
            ssc_pkg::OP_RUN_DIFF:
            begin
                up_reg   <= (target >= filt_reg);
                d_reg    <= (target >= filt_reg) ? target - filt_reg : filt_reg - target;
                nine_reg <= NINE_W'({pwm_reg, 3'b000}) + NINE_W'(pwm_reg);
            end
            ssc_pkg::OP_RUN_MUL:
            begin
                gprod_reg   <= GPROD_W'(d_reg) * GPROD_W'(gain_reg);
                lo_prod_reg <= LOP_W'(pwm_reg[PW-1:1]) * LOP_W'(ssc_pkg::RECIP10);
                hi_prod_reg <= HIP_W'(nine_reg[NINE_W-1:1]) * HIP_W'(ssc_pkg::RECIP10);
            end
            ssc_pkg::OP_RUN_UPD:
            begin
                lo_reg  <= PW'(lo_prod_reg[LOP_W-1:ssc_pkg::RECIP10_SHIFT]) + PW'(1);
                hi9_reg <= PW'(hi_prod_reg[HIP_W-1:ssc_pkg::RECIP10_SHIFT]);
            end
            ssc_pkg::OP_RUN_SPAN:
                span_reg <= (hi9_reg > lo_reg) ? hi9_reg - lo_reg : '0;
            ssc_pkg::OP_RUN_LMUL:
                lprod_reg <= LPROD_W'(level) * LPROD_W'(span_reg);
            ssc_pkg::OP_RUN_QMUL:
                qprod_reg <= QPROD_W'(lprod_reg[LPROD_W-1:2]) * QPROD_W'(ssc_pkg::RECIP100);
            default: ;
        endcase
    end

    assign status.stage = stage_reg;
    assign res          = res_reg;

endmodule

`default_nettype wire

// ----- rtl/six_step_commutation_sequencer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | role   | payload
// ----------+--------+-------------------------------------------------------
// request   | sink   | command (2), throttle (7)
// result    | source | phase mask, duty a/b/c, sense phase/edge, pwm period,
//           |        | step timer period/run, stage, step
// cfg_*     | write  | cfg_index (3) selects register, cfg_data (20)
//
// an item goes from acceptance through the dispatch state and, in ramp, the
// ramp multiply and duty states or, in running, the chain of registered
// multiplies through the filter and duty math (diff, mul, upd, span, lmul,
// qmul, duty), to the emit state, where the result register loads
// a new item is accepted once the previous result sits in the output
// register, even while that result waits on a stalled result channel; the
// new item then holds in the emit state and the input stays blocked
// reset (rst_n low, asynchronous) loads the default registers, stage off,
// step six, duty 100 and clears filter, ramp count and pwm period

module six_step_commutation_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    ssc_req_if.sink                             request,
    ssc_res_if.source                           result,
    input  logic                                cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ssc_pkg::dp_cmd_t    cmd;
    ssc_pkg::dp_status_t status;
    ssc_pkg::res_t       res;
    logic                in_ready;
    logic                out_valid;

    // controller sequences the per-stage arithmetic steps
    ssc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath holds stage, step, filter, duty and the result register
    ssc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_command  (request.command),
        .in_throttle (request.throttle),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res         (res)
    );

    assign request.ready = in_ready;

    // result channel straight from the output register
    assign result.valid             = out_valid;
    assign result.phase_enable_mask = res.phase_enable_mask;
    assign result.duty_a            = res.duty_a;
    assign result.duty_b            = res.duty_b;
    assign result.duty_c            = res.duty_c;
    assign result.sense_phase       = res.sense_phase;
    assign result.sense_rising      = res.sense_rising;
    assign result.pwm_period_out    = res.pwm_period_out;
    assign result.step_timer_period = res.step_timer_period;
    assign result.step_timer_run    = res.step_timer_run;
    assign result.stage_out         = res.stage_out;
    assign result.step_out          = res.step_out;

endmodule

`default_nettype wire

// ----- dv/six_step_commutation_sequencer_core_tb.sv -----
`timescale 1ns / 1ps

module six_step_commutation_sequencer_core_tb;
    import ssc_pkg::*;

    // clocking and run shape
    localparam int CLK_HALF_NS      = 5;
    localparam int RESET_CYCLES     = 9;
    localparam int MAX_GAP          = 16;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 24;
    localparam int REPORT_LIMIT     = 10;
    localparam int RANDOM_ITEMS     = 1750;
    localparam int N_SETTINGS       = 8;

    // long result-side hold to back the block up into its input
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int HOLD_AFTER_FIRST = 150;
    localparam int HOLD_AFTER_LAST  = 1000;
    localparam int N_HOLDS          = 2;

    // register indexes past the last defined register
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 3'd5;
    localparam int N_SPARE_INDEXES = 3;

    // entries of the stimulus queue: an item, a register write, or a pause
    // until every result is back
    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_CFG,
        ENT_DRAIN
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t           kind;
        cmd_t                  cmd;
        logic [THR_W-1:0]      thr;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
    } stim_entry_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ssc_req_if req_ch ();
    ssc_res_if res_ch ();

    six_step_commutation_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // stimulus still to be offered and commutation results still owed
    stim_entry_t queued_commands[$];
    res_t        owed_commutations[$];

    // predictor state, same widths as the block
    logic [2:0]          pr_step;
    stage_t              pr_stage;
    logic [LIMIT_W-1:0]  pr_ramp_cnt;
    logic [FILT_W-1:0]   pr_filt;
    logic [PERIOD_W-1:0] pr_duty;
    logic [PERIOD_W-1:0] pr_pwm;

    // predictor copy of the registers
    logic [PERIOD_W-1:0] cf_align_period;
    logic [PERIOD_W-1:0] cf_ramp_period;
    logic [PERIOD_W-1:0] cf_ramp_pwm;
    logic [LIMIT_W-1:0]  cf_ramp_limit;
    logic [GAIN_W-1:0]   cf_gain;

    // ramp limit as it will stand when the stimulus being built is played
    logic [LIMIT_W-1:0]  plan_limit = RAMP_STEP_LIMIT_RST;

    int stim_items     = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int run_results    = 0;
    int cfg_writes     = 0;
    int mismatches     = 0;
    int errors         = 0;
    int stall_cycles   = 0;

    // sender pacing
    int src_gap;
    bit src_gap_drawn;
    bit src_idle_on;

    // receiver pacing
    int sink_gap;
    int sink_hold;
    int holds_done;
    bit sink_idle_on;

    // one item through the sequencer: stage write, stage handler, then the
    // commutation table for the step it lands on
    function automatic res_t predict_commutation(input cmd_t cmd,
                                                 input logic [THR_W-1:0] thr_in);
        res_t                       r;
        logic [THR_W-1:0]           thr;
        logic [LIMIT_W:0]           next_cnt;
        logic [FILT_W-1:0]          target;
        logic [FILT_W-1:0]          gap_to_target;
        logic [FILT_W+GAIN_W-1:0]   prod;
        logic [FILT_W-1:0]          delta;
        logic [31:0]                level;
        logic [31:0]                lo;
        logic [31:0]                hi9;
        logic [31:0]                span;
        logic [31:0]                pwm32;
        logic [2:0]                 en_mask;
        phase_t                     pwm_ph;
        phase_t                     sense_ph;
        logic                       rise;
        bit                         commutes;

        r = '0;
        r.sense_phase = PHASE_NONE;
        commutes = 1'b0;
        thr = (thr_in > THR_MAX) ? THR_MAX : thr_in;

        case (cmd)
            CMD_ALIGN: pr_stage = STAGE_ALIGN;
            CMD_RAMP:  pr_stage = STAGE_RAMP;
            CMD_STOP:  pr_stage = STAGE_OFF;
            default:   ;
        endcase

        case (pr_stage)
            STAGE_ALIGN:
            begin
                r.step_timer_period = cf_align_period;
                r.step_timer_run = TRUN_ENABLE;
                pr_ramp_cnt = '0;
                commutes = 1'b1;
            end
            STAGE_RAMP:
            begin
                next_cnt = {1'b0, pr_ramp_cnt} + 1'b1;
                r.step_timer_period = cf_ramp_period;
                pr_pwm = cf_ramp_pwm;
                pr_duty = pr_pwm / 16'd30;
                pr_ramp_cnt = next_cnt[LIMIT_W] ? '1 : next_cnt[LIMIT_W-1:0];
                commutes = 1'b1;
                if (next_cnt > {1'b0, cf_ramp_limit})
                    pr_stage = STAGE_RUN;
            end
            STAGE_RUN:
            begin
                r.step_timer_run = TRUN_DISABLE;
                // first-order low-pass toward the saturated throttle
                target = FILT_W'(thr) << FILTER_FRAC_BITS;
                if (target >= pr_filt)
                begin
                    gap_to_target = target - pr_filt;
                    prod = gap_to_target * cf_gain;
                    delta = prod >> GAIN_W;
                    pr_filt = pr_filt + delta;
                end
                else
                begin
                    gap_to_target = pr_filt - target;
                    prod = gap_to_target * cf_gain;
                    delta = prod >> GAIN_W;
                    pr_filt = pr_filt - delta;
                end
                // duty spans min .. 0.9 period by the integer filter level
                level = 32'(pr_filt >> FILTER_FRAC_BITS);
                pwm32 = 32'(pr_pwm);
                lo = pwm32 / 10 + 1;
                hi9 = (pwm32 * 9) / 10;
                span = (hi9 > lo) ? hi9 - lo : 32'd0;
                pr_duty = PERIOD_W'(lo + (level * span) / 100);
                commutes = 1'b1;
            end
            default:
                pr_pwm = '0;
        endcase

        if (commutes)
        begin
            pr_step = (pr_step >= STEP_LAST || pr_step == 3'd0) ? STEP_FIRST
                                                                : pr_step + 3'd1;
            case (pr_step)
                3'd1:    begin en_mask = 3'b011; pwm_ph = PHASE_B; sense_ph = PHASE_C; rise = 1'b0; end
                3'd2:    begin en_mask = 3'b101; pwm_ph = PHASE_C; sense_ph = PHASE_B; rise = 1'b1; end
                3'd3:    begin en_mask = 3'b110; pwm_ph = PHASE_C; sense_ph = PHASE_A; rise = 1'b0; end
                3'd4:    begin en_mask = 3'b011; pwm_ph = PHASE_A; sense_ph = PHASE_C; rise = 1'b1; end
                3'd5:    begin en_mask = 3'b101; pwm_ph = PHASE_A; sense_ph = PHASE_B; rise = 1'b0; end
                default: begin en_mask = 3'b110; pwm_ph = PHASE_B; sense_ph = PHASE_A; rise = 1'b1; end
            endcase
            r.phase_enable_mask = en_mask;
            case (pwm_ph)
                PHASE_A: r.duty_a = pr_duty;
                PHASE_B: r.duty_b = pr_duty;
                default: r.duty_c = pr_duty;
            endcase
            r.sense_phase = sense_ph;
            r.sense_rising = rise;
        end

        r.pwm_period_out = pr_pwm;
        r.stage_out = pr_stage;
        r.step_out = (pr_stage == STAGE_OFF) ? 3'd0 : pr_step;
        return r;
    endfunction

    function automatic string fmt_result(input res_t r);
        return $sformatf({"mask %0d duty %0d/%0d/%0d sense %0d rise %0d pwm %0d",
                          " tper %0d trun %0d stage %0d step %0d"},
                         r.phase_enable_mask, r.duty_a, r.duty_b, r.duty_c,
                         r.sense_phase, r.sense_rising, r.pwm_period_out,
                         r.step_timer_period, r.step_timer_run, r.stage_out,
                         r.step_out);
    endfunction

    // mostly in the valid percent range, sometimes above to hit saturation
    function automatic logic [THR_W-1:0] rand_throttle();
        logic [THR_W-1:0] t;
        if ($urandom_range(0, 9) < 7)
            t = THR_W'($urandom_range(0, THR_MAX));
        else
            t = THR_W'($urandom_range(0, (1 << THR_W) - 1));
        return t;
    endfunction

    task automatic push_item(input cmd_t cmd, input logic [THR_W-1:0] thr);
        stim_entry_t e;
        e = '0;
        e.kind = ENT_ITEM;
        e.cmd = cmd;
        e.thr = thr;
        queued_commands.push_back(e);
        stim_items++;
    endtask

    task automatic push_drain();
        stim_entry_t e;
        e = '0;
        e.kind = ENT_DRAIN;
        queued_commands.push_back(e);
    endtask

    // register write; bits above the register width get random junk at times
    task automatic push_cfg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] value, input int width);
        stim_entry_t e;
        e = '0;
        e.kind = ENT_CFG;
        e.idx = idx;
        e.data = value;
        if (width < CFG_DATA_W && $urandom_range(0, 1) == 1)
            e.data = value | (CFG_DATA_W'($urandom) << width);
        if (idx == CFG_RAMP_STEP_LIMIT)
            plan_limit = value[LIMIT_W-1:0];
        queued_commands.push_back(e);
    endtask

    // one register setting; the first two are the upper and lower extremes
    task automatic push_setting(input int setting);
        logic [PERIOD_W-1:0] align_v;
        logic [PERIOD_W-1:0] ramp_v;
        logic [PERIOD_W-1:0] pwm_v;
        logic [LIMIT_W-1:0]  lim_v;
        logic [GAIN_W-1:0]   gain_v;
        case (setting)
            0:
            begin
                align_v = '1; ramp_v = '1; pwm_v = '1; lim_v = '1; gain_v = '1;
            end
            1:
            begin
                align_v = '0; ramp_v = '0; pwm_v = 16'd1; lim_v = '0; gain_v = '0;
            end
            default:
            begin
                align_v = PERIOD_W'($urandom);
                ramp_v = PERIOD_W'($urandom);
                if ($urandom_range(0, 2) == 0)
                    pwm_v = PERIOD_W'($urandom_range(1, 200));
                else
                    pwm_v = PERIOD_W'($urandom_range(1, (1 << PERIOD_W) - 1));
                if ($urandom_range(0, 5) == 0)
                    lim_v = LIMIT_W'($urandom_range(0, (1 << LIMIT_W) - 1));
                else
                    lim_v = LIMIT_W'($urandom_range(0, 15));
                // spread the gain over every magnitude
                gain_v = GAIN_W'($urandom >> $urandom_range(12, 31));
            end
        endcase
        push_cfg(CFG_ALIGN_STEP_PERIOD, CFG_DATA_W'(align_v), PERIOD_W);
        push_cfg(CFG_RAMP_STEP_PERIOD, CFG_DATA_W'(ramp_v), PERIOD_W);
        push_cfg(CFG_RAMP_PWM_PERIOD, CFG_DATA_W'(pwm_v), PERIOD_W);
        push_cfg(CFG_RAMP_STEP_LIMIT, CFG_DATA_W'(lim_v), LIMIT_W);
        push_cfg(CFG_FILTER_GAIN, CFG_DATA_W'(gain_v), GAIN_W);
        // unused indexes must not disturb any register
        if (setting == 2)
            for (int i = 0; i < N_SPARE_INDEXES; i++)
                push_cfg(CFG_INDEX_SPARE + CFG_INDEX_W'(i), CFG_DATA_W'($urandom),
                         CFG_DATA_W);
    endtask

    // mostly a full start-up (align, ramp to running, run, then at times stop or
    // ramp again) with random throttle; the rest is a burst of arbitrary commands
    task automatic push_session();
        int n_run;
        logic [THR_W-1:0] thr;
        if ($urandom_range(0, 9) < 8)
        begin
            push_item(CMD_ALIGN, rand_throttle());
            repeat ($urandom_range(0, 3)) push_item(CMD_TICK, rand_throttle());
            push_item(CMD_RAMP, rand_throttle());
            repeat (int'(plan_limit)) push_item(CMD_TICK, rand_throttle());
            n_run = $urandom_range(4, 40);
            thr = rand_throttle();
            repeat (n_run)
            begin
                // hold the throttle for a while so the filter can settle
                if ($urandom_range(0, 3) == 0)
                    thr = rand_throttle();
                push_item(CMD_TICK, thr);
            end
            case ($urandom_range(0, 4))
                0, 1:
                begin
                    push_item(CMD_STOP, rand_throttle());
                    repeat ($urandom_range(0, 2)) push_item(CMD_TICK, rand_throttle());
                end
                2:
                    // back into ramp with the count already past the limit
                    push_item(CMD_RAMP, rand_throttle());
                default: ;
            endcase
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                push_item(cmd_t'($urandom_range(0, 3)), rand_throttle());
        end
    endtask

    // driver: presents queued items, performs register writes once the
    // block has handed back every result, and predicts each accepted item
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        stim_entry_t head;
        logic        nxt_valid;
        logic        nxt_we;
        res_t        predicted;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.command <= CMD_TICK;
            req_ch.throttle <= '0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            pr_step = STEP_RST;
            pr_stage = STAGE_OFF;
            pr_ramp_cnt = '0;
            pr_filt = '0;
            pr_duty = DUTY_RST;
            pr_pwm = '0;
            cf_align_period = ALIGN_STEP_PERIOD_RST;
            cf_ramp_period = RAMP_STEP_PERIOD_RST;
            cf_ramp_pwm = RAMP_PWM_PERIOD_RST;
            cf_ramp_limit = RAMP_STEP_LIMIT_RST;
            cf_gain = FILTER_GAIN_RST;
            src_gap = 0;
            src_gap_drawn = 1'b0;
            src_idle_on = 1'b1;
        end
        else
        begin
            nxt_valid = req_ch.valid;
            nxt_we = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                predicted = predict_commutation(cmd_t'(req_ch.command), req_ch.throttle);
                owed_commutations.push_back(predicted);
                items_accepted++;
                if (predicted.stage_out == STAGE_RUN)
                    run_results++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && queued_commands.size() > 0)
            begin
                head = queued_commands[0];
                case (head.kind)
                    ENT_ITEM:
                    begin
                        // gap before each item; idling switches on and off
                        if (!src_gap_drawn)
                        begin
                            if ($urandom_range(0, 63) == 0)
                                src_idle_on = !src_idle_on;
                            src_gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                            src_gap_drawn = 1'b1;
                        end
                        if (src_gap > 0)
                            src_gap--;
                        else
                        begin
                            nxt_valid = 1'b1;
                            req_ch.command <= head.cmd;
                            req_ch.throttle <= head.thr;
                            void'(queued_commands.pop_front());
                            src_gap_drawn = 1'b0;
                        end
                    end
                    ENT_CFG:
                    begin
                        // block is idle once nothing is owed
                        if (owed_commutations.size() == 0)
                        begin
                            nxt_we = 1'b1;
                            cfg_index <= head.idx;
                            cfg_data <= head.data;
                            case (head.idx)
                                CFG_ALIGN_STEP_PERIOD: cf_align_period = head.data[PERIOD_W-1:0];
                                CFG_RAMP_STEP_PERIOD:  cf_ramp_period = head.data[PERIOD_W-1:0];
                                CFG_RAMP_PWM_PERIOD:   cf_ramp_pwm = head.data[PERIOD_W-1:0];
                                CFG_RAMP_STEP_LIMIT:   cf_ramp_limit = head.data[LIMIT_W-1:0];
                                CFG_FILTER_GAIN:       cf_gain = head.data[GAIN_W-1:0];
                                default: ;
                            endcase
                            cfg_writes++;
                            void'(queued_commands.pop_front());
                        end
                    end
                    default:
                    begin
                        if (owed_commutations.size() == 0)
                            void'(queued_commands.pop_front());
                    end
                endcase
            end
            req_ch.valid <= nxt_valid;
            cfg_we <= nxt_we;
        end
    end

    // monitor: checks every accepted result against the oldest prediction
    // and paces ready, including the long holds that back up the input
    always @(posedge clk or negedge rst_n)
    begin : check_results
        res_t seen;
        res_t want;
        logic nxt_ready;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            sink_gap = 0;
            sink_hold = 0;
            holds_done = 0;
            sink_idle_on = 1'b1;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                seen = {res_ch.phase_enable_mask, res_ch.duty_a, res_ch.duty_b,
                        res_ch.duty_c, res_ch.sense_phase, res_ch.sense_rising,
                        res_ch.pwm_period_out, res_ch.step_timer_period,
                        res_ch.step_timer_run, res_ch.stage_out, res_ch.step_out};
                results_seen++;
                if (owed_commutations.size() == 0)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing owed: %s",
                                 results_seen, fmt_result(seen));
                end
                else
                begin
                    want = owed_commutations.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result %0d mismatch\n  expected %s\n  actual   %s",
                                     results_seen, fmt_result(want), fmt_result(seen));
                    end
                end
                // hold off for long while the sender is still offering
                if (holds_done < N_HOLDS && req_ch.valid &&
                    results_seen >= (holds_done == 0 ? HOLD_AFTER_FIRST : HOLD_AFTER_LAST))
                begin
                    sink_hold = SINK_HOLD_CYCLES;
                    holds_done++;
                end
                if ($urandom_range(0, 63) == 0)
                    sink_idle_on = !sink_idle_on;
                sink_gap = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                nxt_ready = 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            res_ch.ready <= nxt_ready;
        end
    end

    // watchdog on cycles with no progress on any port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("six_step_commutation_sequencer_core verification failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : run_test
        int budget;

        // known levels on every input before reset takes hold
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_TICK;
        req_ch.throttle = '0;
        res_ch.ready = 1'b0;

        // directed start-up under the reset registers
        push_item(CMD_TICK, 7'd0);            // tick while off
        push_item(CMD_STOP, 7'd127);          // stop while off, throttle over range
        push_item(CMD_ALIGN, 7'd100);
        push_item(CMD_TICK, 7'd0);            // align keeps commutating
        push_item(CMD_RAMP, 7'd0);
        repeat (int'(RAMP_STEP_LIMIT_RST))    // ramp until the count passes the limit
            push_item(CMD_TICK, rand_throttle());
        push_item(CMD_TICK, 7'd100);          // running, full throttle
        push_item(CMD_TICK, 7'd127);          // saturated throttle
        push_item(CMD_TICK, 7'd0);
        push_item(CMD_RAMP, 7'd50);           // re-enter ramp, count already past limit
        push_item(CMD_ALIGN, 7'd50);          // align from running clears the count
        push_item(CMD_STOP, 7'd50);
        push_item(CMD_TICK, 7'd50);           // off keeps the step
        push_item(CMD_RAMP, 7'd1);            // ramp straight from off
        push_drain();

        // random sessions under a series of register settings
        for (int s = 0; s < N_SETTINGS; s++)
        begin
            push_setting(s);
            budget = stim_items + RANDOM_ITEMS / N_SETTINGS;
            while (stim_items < budget)
            begin
                push_session();
                // sender pause mid-way until the block has emptied
                if (stim_items >= budget - RANDOM_ITEMS / (2 * N_SETTINGS) &&
                    stim_items < budget - RANDOM_ITEMS / (2 * N_SETTINGS) + 12)
                    push_drain();
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (queued_commands.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (owed_commutations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (owed_commutations.size() != 0)
            errors += owed_commutations.size();

        $display("%0d items through all stages, %0d results checked, %0d in running stage",
                 items_accepted, results_seen, run_results);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 cfg_writes, N_SETTINGS, mismatches);
        if (errors == 0)
            $display("six_step_commutation_sequencer_core verification clean");
        else
            $display("six_step_commutation_sequencer_core verification failed");
        $finish;
    end

endmodule
